### rtl/core/positional_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent assertion forms used by the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

### rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Item types, command codes and cell control shared by the list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned OUT_CNT_W    = 5;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOCATE = 2'd2;

  typedef struct packed {
    logic [1:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic                        ok;
    logic signed [VAL_W-1:0]     removed_value;
    logic [OUT_CNT_W-1:0]        found_at;
    logic [OUT_CNT_W-1:0]        count;
  } rsp_item_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

### rtl/core/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed words with insert, delete and locate commands.
// ----------------------------------------------------------------------------
// Insert, delete and an unused command code complete in the accepting cycle:
// a good insert or delete shifts the entries at or after the position by one
// cell, and the result is registered at that edge. Locate compares all
// entries at once, then shifts the match bits one cell per cycle toward the
// head until the head bit is set or the scan index reaches the count, and
// then waits for a free result register. A new item is taken once the chain
// is idle and the result register is free or being emptied.
`include "positional_list_engine_macros.svh"

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int unsigned RN = (CAPACITY < 31) ? CAPACITY : 31;

  state_t           state;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    idx;
  logic             cmd_acc;
  logic             out_free;
  logic             ins_ok;
  logic             del_ok;
  logic             scan_done;
  logic             rsp_set;
  logic [EW-1:0]    pos_e;
  logic [EW-1:0]    cnt_e;
  logic [VAL_W-1:0] removed;
  cell_ctrl_t       ctrl;
  logic [VAL_W-1:0] data_w [CAPACITY];
  logic             match_w [CAPACITY];

  assign out_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = !((state == S_IDLE) && out_free);
  assign cmd_acc   = cmd_valid && !cmd_stall;

  assign pos_e  = EW'(cmd.position);
  assign cnt_e  = EW'(count_q);
  assign ins_ok = (cmd.command == CMD_INSERT) && (pos_e != '0) &&
                  (pos_e <= cnt_e + EW'(1)) && (cnt_e < EW'(CAPACITY));
  assign del_ok = (cmd.command == CMD_DELETE) && (pos_e != '0) && (pos_e <= cnt_e);

  assign scan_done = (state == S_SCAN) && ((idx >= count_q) || match_w[0]);
  assign rsp_set   = (cmd_acc && (cmd.command != CMD_LOCATE)) || (scan_done && out_free);

  always_comb begin
    ctrl.ins   = cmd_acc && ins_ok;
    ctrl.del   = cmd_acc && del_ok;
    ctrl.load  = cmd_acc && (cmd.command == CMD_LOCATE);
    ctrl.shift = (state == S_SCAN) && !scan_done;
  end

  always_comb begin
    count_next = count_q;
    if (ctrl.ins) begin
      count_next = count_q + CW'(1);
    end else if (ctrl.del) begin
      count_next = count_q - CW'(1);
    end
  end

  always_comb begin
    removed = '0;
    for (int i = 0; i < RN; i++) begin
      if (pos_e == EW'(i + 1)) begin
        removed = removed | data_w[i];
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_d;
    logic [VAL_W-1:0] right_d;
    logic             right_m;

    if (g == 0) begin : g_head
      assign left_d = cmd.value;
    end else begin : g_mid
      assign left_d = data_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = data_w[g];
      assign right_m = 1'b0;
    end else begin : g_body
      assign right_d = data_w[g+1];
      assign right_m = match_w[g+1];
    end

    ple_cell #(
      .IDX   (g),
      .CNT_W (CW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .position    (cmd.position),
      .count       (count_q),
      .value       (cmd.value),
      .left_data   (left_d),
      .right_data  (right_d),
      .right_match (right_m),
      .data        (data_w[g]),
      .match       (match_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_q   <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count_q <= count_next;
      if (rsp_set) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_acc && (cmd.command == CMD_LOCATE)) begin
            state <= S_SCAN;
            idx   <= '0;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc && (cmd.command != CMD_LOCATE)) begin
      rsp.ok            <= ins_ok || del_ok;
      rsp.removed_value <= del_ok ? removed : '0;
      rsp.found_at      <= '0;
      rsp.count         <= OUT_CNT_W'(count_next);
    end else if (scan_done && out_free) begin
      rsp.ok            <= 1'b1;
      rsp.removed_value <= '0;
      rsp.found_at      <= (match_w[0] && (idx < count_q)) ? OUT_CNT_W'(idx + CW'(1)) : '0;
      rsp.count         <= OUT_CNT_W'(count_q);
    end
  end

  // The count never passes the capacity of the chain.
  `PLE_ASSERT_SAME(a_count_cap, clk, rst, 1'b1, count_q <= CW'(CAPACITY))
  // No item is taken while a locate scan runs.
  `PLE_ASSERT_SAME(a_scan_stall, clk, rst, state == S_SCAN, cmd_stall)
  // A good insert grows the list by exactly one entry.
  `PLE_ASSERT_NEXT(a_ins_grow, clk, rst, ctrl.ins, count_q == $past(count_q) + CW'(1))
  // A good delete shrinks the list by exactly one entry.
  `PLE_ASSERT_NEXT(a_del_shrink, clk, rst, ctrl.del, count_q == $past(count_q) - CW'(1))

endmodule

### rtl/core/ple_cell.sv
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry and one match bit, exchanging both with its neighbors.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [POS_W-1:0] position,
  input  logic [CNT_W-1:0] count,
  input  logic [VAL_W-1:0] value,
  input  logic [VAL_W-1:0] left_data,
  input  logic [VAL_W-1:0] right_data,
  input  logic             right_match,
  output logic [VAL_W-1:0] data,
  output logic             match
);

  localparam int unsigned SLOT = IDX + 1;

  logic at_pos;
  logic after_pos;
  logic in_list;

  assign at_pos    = (SLOT == 32'(position));
  assign after_pos = (SLOT > 32'(position));
  assign in_list   = (IDX < 32'(count));

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (at_pos) begin
        data <= value;
      end else if (after_pos) begin
        data <= left_data;
      end
    end else if (ctrl.del) begin
      if (at_pos || after_pos) begin
        data <= right_data;
      end
    end
    if (ctrl.load) begin
      match <= (data == value) && in_list;
    end else if (ctrl.shift) begin
      match <= right_match;
    end
  end

endmodule

### verif/positional_list_engine_test.sv
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives insert, delete, locate and unused commands into the list engine,
// first from a short table of directed rows and then from a random mix that
// alternates between filling and draining the list. Each accepted command is
// run through a local list predictor, and each accepted response is compared
// field by field with the oldest expected one, taken from the table for typed
// directed rows and from the predictor otherwise. Both channels idle in random
// bursts, and once the response side holds off long enough to back up the command side.
// ----------------------------------------------------------------------------
module positional_list_engine_test;
  import ple_pkg::*;

  localparam int DEPTH          = CAPACITY_DEF;
  localparam int NUM_RANDOM     = 1820;
  localparam int CALM_ITEMS     = 200;
  localparam int HOLD_AT        = 300;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 3 * DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    cmd_item_t item;
    int        reps;
    bit        typed;
    rsp_item_t result;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_item_t cmd;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_item_t rsp;

  logic signed [VAL_W-1:0] list_words [DEPTH];
  int                      list_len = 0;
  rsp_item_t               expected_results [$];
  dir_row_t                plan [$];
  bit                      row_is_typed = 1'b0;
  rsp_item_t               row_result = '0;
  bit                      hold_off_req = 1'b0;
  bit                      calm = 1'b0;
  int                      mismatches = 0;
  int                      idle_cycles = 0;

  positional_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  function automatic rsp_item_t apply_command(input cmd_item_t c);
    rsp_item_t r;
    int        p;
    int        k;
    r = '0;
    p = int'(c.position);
    case (c.command)
      CMD_INSERT: begin
        if (p >= 1 && p <= list_len + 1 && list_len < DEPTH) begin
          for (k = list_len; k >= p; k--) list_words[k] = list_words[k-1];
          list_words[p-1] = c.value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          r.removed_value = list_words[p-1];
          for (k = p; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
          r.ok = 1'b1;
        end
      end
      CMD_LOCATE: begin
        for (k = 0; k < list_len; k++) begin
          if (r.found_at == 0 && list_words[k] == c.value) r.found_at = OUT_CNT_W'(k + 1);
        end
        r.ok = 1'b1;
      end
      default: begin
        r.ok = 1'b0;
      end
    endcase
    r.count = OUT_CNT_W'(list_len);
    return r;
  endfunction

  function automatic dir_row_t mk(input logic [1:0] command, input int position,
                                  input logic signed [VAL_W-1:0] value, input int reps,
                                  input bit typed, input bit ok,
                                  input logic signed [VAL_W-1:0] removed,
                                  input int found, input int count);
    dir_row_t d;
    d.item.command         = command;
    d.item.position        = POS_W'(position);
    d.item.value           = value;
    d.reps                 = reps;
    d.typed                = typed;
    d.result.ok            = ok;
    d.result.removed_value = removed;
    d.result.found_at      = OUT_CNT_W'(found);
    d.result.count         = OUT_CNT_W'(count);
    return d;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7fff_ffff;
      2, 3, 4: v = $signed($urandom_range(0, 6)) - 32'sd3;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic cmd_item_t next_command(input bit filling);
    cmd_item_t c;
    int        r;
    r = $urandom_range(0, 99);
    c.value    = pick_value();
    c.position = POS_W'($urandom_range(0, 31));
    if (r < 3) begin
      c.command = CMD_UNUSED;
    end else if (r < (filling ? 50 : 25)) begin
      c.command = CMD_INSERT;
      if ($urandom_range(0, 7) != 0) c.position = POS_W'($urandom_range(1, list_len + 1));
    end else if (r < 75) begin
      c.command = CMD_DELETE;
      if (list_len > 0 && $urandom_range(0, 7) != 0)
        c.position = POS_W'($urandom_range(1, list_len));
    end else begin
      c.command = CMD_LOCATE;
      if (list_len > 0 && $urandom_range(0, 2) != 0)
        c.value = list_words[$urandom_range(0, list_len - 1)];
    end
    return c;
  endfunction

  task automatic drive_item(input cmd_item_t c, input bit typed, input rsp_item_t result);
    if (!calm && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    cmd          <= c;
    cmd_valid    <= 1'b1;
    row_is_typed = typed;
    row_result   = result;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_result(input rsp_item_t got);
    rsp_item_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: ok=%0d count=%0d", got.ok, got.count);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, actual %0d", want.ok, got.ok);
        mismatches++;
      end
      if (got.removed_value !== want.removed_value) begin
        $error("removed_value: expected %h, actual %h", want.removed_value, got.removed_value);
        mismatches++;
      end
      if (got.found_at !== want.found_at) begin
        $error("found_at: expected %0d, actual %0d", want.found_at, got.found_at);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, got.count);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        if (row_is_typed) begin
          void'(apply_command(cmd));
          expected_results.push_back(row_result);
        end else begin
          expected_results.push_back(apply_command(cmd));
        end
      end
      if (rsp_valid && !rsp_stall) check_result(rsp);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** positional_list_engine: FAILED **");
        $finish;
      end
    end
  end

  initial begin : response_side
    rsp_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  initial begin : command_side
    dir_row_t  d;
    cmd_item_t c;
    int        n;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;

    plan.push_back(mk(CMD_LOCATE, 0, 0, 1, 1, 1, 0, 0, 0));
    plan.push_back(mk(CMD_DELETE, 1, 0, 1, 1, 0, 0, 0, 0));
    plan.push_back(mk(CMD_INSERT, 0, 1, 1, 1, 0, 0, 0, 0));
    plan.push_back(mk(CMD_INSERT, 2, 1, 1, 1, 0, 0, 0, 0));
    plan.push_back(mk(CMD_UNUSED, 31, -1, 1, 1, 0, 0, 0, 0));
    plan.push_back(mk(CMD_INSERT, 1, 32'sh8000_0000, 1, 1, 1, 0, 0, 1));
    plan.push_back(mk(CMD_INSERT, 2, 32'sh7fff_ffff, 1, 1, 1, 0, 0, 2));
    plan.push_back(mk(CMD_INSERT, 1, -1, 1, 1, 1, 0, 0, 3));
    plan.push_back(mk(CMD_LOCATE, 0, 32'sh7fff_ffff, 1, 1, 1, 0, 3, 3));
    plan.push_back(mk(CMD_LOCATE, 31, 32'sh8000_0000, 1, 1, 1, 0, 2, 3));
    plan.push_back(mk(CMD_DELETE, 31, 0, 1, 1, 0, 0, 0, 3));
    plan.push_back(mk(CMD_DELETE, 4, 0, 1, 1, 0, 0, 0, 3));
    plan.push_back(mk(CMD_DELETE, 2, 0, 1, 1, 1, 32'sh8000_0000, 0, 2));
    plan.push_back(mk(CMD_INSERT, 3, 5, 1, 1, 1, 0, 0, 3));
    plan.push_back(mk(CMD_INSERT, 1, 5, 1, 1, 1, 0, 0, 4));
    plan.push_back(mk(CMD_LOCATE, 0, 5, 1, 1, 1, 0, 1, 4));
    plan.push_back(mk(CMD_INSERT, 2, 100, 12, 0, 0, 0, 0, 0));
    plan.push_back(mk(CMD_INSERT, 17, 0, 1, 1, 0, 0, 0, 16));
    plan.push_back(mk(CMD_INSERT, 1, 0, 1, 1, 0, 0, 0, 16));
    plan.push_back(mk(CMD_LOCATE, 0, 32'sh1234_5678, 1, 1, 1, 0, 0, 16));
    plan.push_back(mk(CMD_LOCATE, 0, 32'sh7fff_ffff, 1, 0, 0, 0, 0, 0));
    plan.push_back(mk(CMD_DELETE, 17, 0, 1, 1, 0, 0, 0, 16));
    plan.push_back(mk(CMD_DELETE, 16, 0, 1, 0, 0, 0, 0, 0));
    plan.push_back(mk(CMD_UNUSED, 0, 0, 1, 1, 0, 0, 0, 15));

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      d = plan[i];
      for (n = 0; n < d.reps; n++) begin
        c = d.item;
        c.value = d.item.value + n;
        drive_item(c, d.typed, d.result);
      end
    end

    for (n = 0; n < NUM_RANDOM; n++) begin
      if (n == HOLD_AT) hold_off_req = 1'b1;
      calm = (n >= NUM_RANDOM - CALM_ITEMS);
      drive_item(next_command(((n / 96) % 2) == 0), 1'b0, '0);
    end

    cmd_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** positional_list_engine: PASSED **");
    end else begin
      $display("** positional_list_engine: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/positional_list_engine.sv
verif/positional_list_engine_test.sv
